@@ sv/fbfla_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfla_pkg
// Shared sizes, status codes and register indexes for the fixed block
// free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  // pool geometry
  localparam int BLOCKS = 128;
  localparam int IDX_W  = $clog2(BLOCKS);      // block index width
  localparam int CNT_W  = IDX_W + 1;           // holds 0..BLOCKS
  localparam int ALIGN  = 16;
  localparam int ALIGN_W = $clog2(ALIGN);

  // block size register: 21-bit raw value, rounded value can reach 2^21
  localparam int BS_RAW_W = 21;
  localparam int BS_W     = BS_RAW_W + 1;
  localparam int MUL_W    = IDX_W + BS_W;      // index * block size
  localparam int STEP_W   = $clog2(IDX_W);     // divider step counter

  localparam logic [BS_W-1:0] BS_RESET   = BS_W'(65536);
  localparam logic [31:0]     BASE_RESET = 32'd65536;

  // operations
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_GRANTED   = 3'd0;
  localparam status_t ST_FALLBACK  = 3'd1;
  localparam status_t ST_RETURNED  = 3'd2;
  localparam status_t ST_NOT_OWNED = 3'd3;
  localparam status_t ST_NULL      = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

  // register word indexes (paddr[2])
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_BASE_ADDR  = 1'b1;

endpackage

@@ sv/fbfla_ram.sv @@
// ----------------------------------------------------------------------------
// fbfla_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/fixed_block_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Pool of equal blocks handed out from a LIFO free list of block indices held
// in a RAM. Allocates pop the list, releases are range/alignment checked by
// a small restoring divider and pushed back.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  in_operation, in_request_size,
//                                         in_address
//  out_     output     out_valid/out_stall out_status, out_block_address,
//                                         out_free_blocks, out_used_blocks,
//                                         out_peak_used_blocks,
//                                         out_fallback_total, out_allocate_total
//  cfg      APB        psel/penable/pready block_size (0x0), base_address (0x4)
//
//  One item at a time. A granted allocate goes through accept, RAM read
//  and index * block size multiply, base add and result load; a release
//  that is in range goes through accept, 7 divider steps of the quotient,
//  check and push, and result load. Fallback, null and out-of-range items
//  go through accept and result load.
//  Reset needs no clearing pass: a low-water mark of the list depth tells
//  which RAM entries were written; others read as their own position.
//  A new item is taken while the last transfer waits on out_stall.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core
  import fbfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_address,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [7:0]  out_free_blocks,
  output logic [7:0]  out_used_blocks,
  output logic [7:0]  out_peak_used_blocks,
  output logic [31:0] out_fallback_total,
  output logic [31:0] out_allocate_total,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // round a raw block size up to the alignment, zero counts as one
  function automatic logic [BS_W-1:0] round_bs(input logic [BS_RAW_W-1:0] raw);
    logic [BS_W-1:0] v;
    logic [BS_W-1:0] s;
    v = (raw == '0) ? BS_W'(1) : BS_W'(raw);
    s = v + BS_W'(ALIGN - 1);
    return {s[BS_W-1:ALIGN_W], ALIGN_W'(0)};
  endfunction

  // registers
  logic [2:0]        state_r,   state_nxt;
  logic [BS_W-1:0]   bs_r,      bs_nxt;
  logic [31:0]       base_r,    base_nxt;
  logic [CNT_W-1:0]  depth_r,   depth_nxt;
  logic [CNT_W-1:0]  low_r,     low_nxt;
  logic [CNT_W-1:0]  used_r,    used_nxt;
  logic [CNT_W-1:0]  peak_r,    peak_nxt;
  logic [31:0]       fb_r,      fb_nxt;
  logic [31:0]       req_r,     req_nxt;
  logic [IDX_W-1:0]  pos_r,     pos_nxt;
  logic              ent_ok_r,  ent_ok_nxt;
  logic [MUL_W-1:0]  prod_r,    prod_nxt;
  logic [MUL_W-1:0]  rem_r,     rem_nxt;
  logic [MUL_W-1:0]  dvs_r,     dvs_nxt;
  logic [IDX_W-1:0]  quo_r,     quo_nxt;
  logic [STEP_W-1:0] step_r,    step_nxt;
  status_t           res_st_r,  res_st_nxt;
  logic [31:0]       res_adr_r, res_adr_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_st_r,  out_st_nxt;
  logic [31:0]       out_adr_r, out_adr_nxt;
  logic [7:0]        out_free_r, out_free_nxt;
  logic [7:0]        out_used_r, out_used_nxt;
  logic [7:0]        out_peak_r, out_peak_nxt;
  logic [31:0]       out_fb_r,  out_fb_nxt;
  logic [31:0]       out_req_r, out_req_nxt;

  // free list RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  // decode helpers
  logic             accept;
  logic             cfg_wr;
  logic [31:0]      size_eff;
  logic             size_fits;
  logic [CNT_W-1:0] depth_m1;
  logic [31:0]      diff;
  logic             in_range;
  logic             div_ge;
  logic [IDX_W-1:0] idx_sel;
  logic             out_free_slot;

  fbfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (BLOCKS)
  ) u_free_list (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // handshakes
  assign in_stall      = (state_r != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_free_slot = !out_valid_r || !out_stall;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;

  // register read back
  assign prdata = (paddr[2] == REG_BASE_ADDR) ? base_r : 32'(bs_r);

  // item decode
  assign size_eff  = (in_request_size == '0) ? 32'd1 : in_request_size;
  assign size_fits = (size_eff <= 32'(bs_r)) && (depth_r != '0);
  assign depth_m1  = depth_r - CNT_W'(1);
  assign diff      = in_address - base_r;
  assign in_range  = (in_address >= base_r) &&
                     (diff < 32'({bs_r, IDX_W'(0)}));

  // divider step and popped index
  assign div_ge  = (rem_r >= dvs_r);
  assign idx_sel = ent_ok_r ? ram_rdata : pos_r;

  // RAM access
  assign ram_re    = accept && (in_operation == OP_ALLOC) && size_fits;
  assign ram_raddr = depth_m1[IDX_W-1:0];
  assign ram_we    = (state_r == S_CHK) && (rem_r == '0) &&
                     (depth_r < CNT_W'(BLOCKS));
  assign ram_waddr = depth_r[IDX_W-1:0];
  assign ram_wdata = quo_r;

  // next state
  always_comb begin
    state_nxt     = state_r;
    bs_nxt        = bs_r;
    base_nxt      = base_r;
    depth_nxt     = depth_r;
    low_nxt       = low_r;
    used_nxt      = used_r;
    peak_nxt      = peak_r;
    fb_nxt        = fb_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    ent_ok_nxt    = ent_ok_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    res_st_nxt    = res_st_r;
    res_adr_nxt   = res_adr_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_adr_nxt   = out_adr_r;
    out_free_nxt  = out_free_r;
    out_used_nxt  = out_used_r;
    out_peak_nxt  = out_peak_r;
    out_fb_nxt    = out_fb_r;
    out_req_nxt   = out_req_r;

    // configuration writes
    if (cfg_wr) begin
      if (paddr[2] == REG_BLOCK_SIZE) begin
        bs_nxt = round_bs(pwdata[BS_RAW_W-1:0]);
      end else begin
        base_nxt = pwdata;
      end
    end

    // output transfer drains the result register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_adr_nxt = '0;
          if (in_operation == OP_ALLOC) begin
            req_nxt = (req_r == '1) ? req_r : req_r + 32'd1;
            if (size_fits) begin
              depth_nxt  = depth_m1;
              used_nxt   = used_r + CNT_W'(1);
              if (used_nxt > peak_r) begin
                peak_nxt = used_nxt;
              end
              pos_nxt    = depth_m1[IDX_W-1:0];
              ent_ok_nxt = (depth_m1 >= low_r);
              if (depth_m1 < low_r) begin
                low_nxt = depth_m1;
              end
              state_nxt  = S_RD;
            end else begin
              fb_nxt     = (fb_r == '1) ? fb_r : fb_r + 32'd1;
              res_st_nxt = ST_FALLBACK;
              state_nxt  = S_DONE;
            end
          end else if (in_address == '0) begin
            res_st_nxt = ST_NULL;
            state_nxt  = S_DONE;
          end else if (!in_range) begin
            res_st_nxt = ST_NOT_OWNED;
            state_nxt  = S_DONE;
          end else begin
            rem_nxt   = diff[MUL_W-1:0];
            dvs_nxt   = MUL_W'(bs_r) << (IDX_W - 1);
            quo_nxt   = '0;
            step_nxt  = STEP_W'(IDX_W - 1);
            state_nxt = S_DIV;
          end
        end
      end

      // popped index times block size
      S_RD: begin
        prod_nxt  = MUL_W'(idx_sel) * MUL_W'(bs_r);
        state_nxt = S_ADD;
      end

      S_ADD: begin
        res_adr_nxt = base_r + 32'(prod_r);
        res_st_nxt  = ST_GRANTED;
        state_nxt   = S_DONE;
      end

      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (div_ge) begin
          rem_nxt = rem_r - dvs_r;
        end
        quo_nxt = {quo_r[IDX_W-2:0], div_ge};
        dvs_nxt = dvs_r >> 1;
        if (step_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end

      // alignment and room check, then push
      S_CHK: begin
        if (rem_r != '0) begin
          res_st_nxt = ST_NOT_OWNED;
        end else if (depth_r >= CNT_W'(BLOCKS)) begin
          res_st_nxt = ST_FULL;
        end else begin
          depth_nxt  = depth_r + CNT_W'(1);
          if (used_r != '0) begin
            used_nxt = used_r - CNT_W'(1);
          end
          res_st_nxt = ST_RETURNED;
        end
        state_nxt = S_DONE;
      end

      // load result register once it is free
      S_DONE: begin
        if (out_free_slot) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_adr_nxt   = res_adr_r;
          out_free_nxt  = 8'(depth_r);
          out_used_nxt  = 8'(used_r);
          out_peak_nxt  = 8'(peak_r);
          out_fb_nxt    = fb_r;
          out_req_nxt   = req_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bs_r        <= BS_RESET;
      base_r      <= BASE_RESET;
      depth_r     <= CNT_W'(BLOCKS);
      low_r       <= CNT_W'(BLOCKS);
      used_r      <= '0;
      peak_r      <= '0;
      fb_r        <= '0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bs_r        <= bs_nxt;
      base_r      <= base_nxt;
      depth_r     <= depth_nxt;
      low_r       <= low_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      fb_r        <= fb_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    ent_ok_r   <= ent_ok_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    res_st_r   <= res_st_nxt;
    res_adr_r  <= res_adr_nxt;
    out_st_r   <= out_st_nxt;
    out_adr_r  <= out_adr_nxt;
    out_free_r <= out_free_nxt;
    out_used_r <= out_used_nxt;
    out_peak_r <= out_peak_nxt;
    out_fb_r   <= out_fb_nxt;
    out_req_r  <= out_req_nxt;
  end

  // result port
  assign out_valid            = out_valid_r;
  assign out_status           = out_st_r;
  assign out_block_address    = out_adr_r;
  assign out_free_blocks      = out_free_r;
  assign out_used_blocks      = out_used_r;
  assign out_peak_used_blocks = out_peak_r;
  assign out_fallback_total   = out_fb_r;
  assign out_allocate_total   = out_req_r;

  // list depth never exceeds the pool
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(BLOCKS))
    else $error("free list depth above pool size");

  // low-water mark stays at or below the list depth
  a_low_water: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= depth_r)
    else $error("low-water mark above list depth");

  // free plus in-use blocks never exceed the pool
  a_pool_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, depth_r} + {1'b0, used_r}) <= (CNT_W + 1)'(BLOCKS))
    else $error("free and used counts exceed pool");

  // a RAM read only follows an accepted allocate
  a_rd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> $past(ram_re))
    else $error("free list read without an accepted allocate");

  // only grants carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_GRANTED)) |-> (out_adr_r == '0))
    else $error("address on a result that is not a grant");

endmodule
